### design/bucketed_delta_list_timer_engine_assert.svh
// Assertion macros for the timer engine.
`ifndef BUCKETED_DELTA_LIST_TIMER_ENGINE_ASSERT_SVH
`define BUCKETED_DELTA_LIST_TIMER_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define BDLT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BDLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BDLT_ASSERT(lbl, clk, rst_n, prop, msg)
`define BDLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### design/bdlt_pkg.sv
package bdlt_pkg;

    typedef enum logic [5:0] {
        ST_CLR, ST_IDLE, ST_DONE,
        ST_SET0, ST_SET1,
        ST_KIL0, ST_KIL1, ST_KIL2, ST_KIL3, ST_KIL4,
        ST_TAK0, ST_TAK1, ST_TAK2, ST_TAK3,
        ST_REL0, ST_REL1,
        ST_SHR0, ST_SHR1, ST_SHR2, ST_SHR3, ST_SHR4, ST_SHR5,
        ST_BKT0, ST_BKT1, ST_BKT2, ST_BKT3, ST_BKT4, ST_BKT5, ST_BKT6,
        ST_FIL0, ST_FIL1, ST_FIL2, ST_FIL3, ST_FIL4,
        ST_UNL0, ST_UNL1, ST_UNL2,
        ST_PUT0, ST_PUT1, ST_PUT2
    } t_state;

    typedef enum logic [2:0] {
        KIND_SET  = 3'd0,
        KIND_KILL = 3'd1,
        KIND_TICK = 3'd2,
        KIND_TAKE = 3'd3,
        KIND_REL  = 3'd4
    } t_kind;

    localparam logic [2:0] STAT_OK     = 3'd0;
    localparam logic [2:0] STAT_NOFREE = 3'd1;
    localparam logic [2:0] STAT_BADTAG = 3'd2;
    localparam logic [2:0] STAT_IGN    = 3'd3;
    localparam logic [2:0] STAT_NONE   = 3'd4;

    localparam int BUCKET_COUNT = 8;
    localparam logic [15:0] SHORT_LIMIT = 16'd5;
    localparam logic [7:0]  TAG_LIMIT   = 8'd8;

    function automatic logic [2:0] pick_bucket(input logic [15:0] len);
        logic [2:0] b;
        if (len >= 16'd5000)      b = 3'd6;
        else if (len >= 16'd1000) b = 3'd5;
        else if (len >= 16'd500)  b = 3'd4;
        else if (len >= 16'd100)  b = 3'd3;
        else if (len >= 16'd50)   b = 3'd2;
        else if (len >= 16'd10)   b = 3'd1;
        else                      b = 3'd0;
        return b;
    endfunction

    function automatic logic [15:0] bucket_gran(input logic [2:0] b);
        logic [15:0] g;
        case (b)
            3'd0:    g = 16'd5;
            3'd1:    g = 16'd10;
            3'd2:    g = 16'd50;
            3'd3:    g = 16'd100;
            3'd4:    g = 16'd500;
            3'd5:    g = 16'd1000;
            3'd6:    g = 16'd5000;
            default: g = 16'd10000;
        endcase
        return g;
    endfunction

endpackage

### design/bdlt_req_if.sv
interface bdlt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [15:0] length;
    logic [7:0]  tag;
    logic [15:0] context_req;
    logic [7:0]  owner;
    logic [15:0] timer_id;

    modport source(output valid, kind, length, tag, context_req, owner, timer_id,
                   input ready);
    modport sink(input valid, kind, length, tag, context_req, owner, timer_id,
                 output ready);
endinterface

### design/bdlt_rsp_if.sv
interface bdlt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  result_id;
    logic [7:0]  result_owner;
    logic [2:0]  result_tag;
    logic [15:0] result_context;

    modport source(output valid, status, result_id, result_owner, result_tag,
                   result_context, input ready);
    modport sink(input valid, status, result_id, result_owner, result_tag,
                 result_context, output ready);
endinterface

### design/bucketed_delta_list_timer_engine.sv
// Channel   Dir  Modport  Payload
// i_req     in   sink     kind, length, tag, context_req, owner, timer_id
// o_rsp     out  source   status, result_id, result_owner, result_tag, result_context
//
// One transaction at a time; each memory access is a registered read followed by writes.
// A tick counts down the short list, then each bucket in turn, refiling the entries that come due.
// After reset a clearing pass over all TIMER_COUNT + QUEUE_COUNT nodes builds the lists.
// A result waits in the output register; a stalled output holds the sequencer in DONE.
module bucketed_delta_list_timer_engine #(
    parameter int TIMER_COUNT = 256,
    parameter int QUEUE_COUNT = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bdlt_req_if.sink         i_req,
    bdlt_rsp_if.source       o_rsp
);

    `include "bucketed_delta_list_timer_engine_assert.svh"

    localparam int NODE_COUNT = TIMER_COUNT + QUEUE_COUNT;
    localparam int NW = $clog2(NODE_COUNT);
    localparam int TW = $clog2(TIMER_COUNT);
    localparam int CW = $clog2(TIMER_COUNT);
    localparam logic [NW-1:0] ROOT_FREE  = NW'(TIMER_COUNT);
    localparam logic [NW-1:0] ROOT_EXP   = NW'(TIMER_COUNT + 1);
    localparam logic [NW-1:0] ROOT_SHORT = NW'(TIMER_COUNT + 2);
    localparam logic [NW-1:0] ROOT_B5    = NW'(TIMER_COUNT + 3);
    localparam logic [NW-1:0] NODE_LAST  = NW'(NODE_COUNT - 1);
    localparam logic [NW-1:0] TIMER_LAST = NW'(TIMER_COUNT - 1);
    localparam logic [NW-1:0] TCN        = NW'(TIMER_COUNT);
    localparam logic [15:0]   TC16       = 16'(TIMER_COUNT);
    localparam logic [CW-1:0] CNT_LAST   = CW'(TIMER_COUNT - 1);
    localparam logic [2:0]    B_LAST     = 3'(bdlt_pkg::BUCKET_COUNT - 1);

    logic [NW-1:0] r_mem_next [NODE_COUNT];
    logic [NW-1:0] r_mem_prev [NODE_COUNT];
    logic [NW-1:0] r_mem_home [NODE_COUNT];
    logic [15:0]   r_mem_delta[NODE_COUNT];
    logic [15:0]   r_mem_rem  [TIMER_COUNT];
    logic [7:0]    r_mem_own  [TIMER_COUNT];
    logic [2:0]    r_mem_tag  [TIMER_COUNT];
    logic [15:0]   r_mem_ctx  [TIMER_COUNT];

    logic [NW-1:0] r_rd_next, r_rd_prev, r_rd_home;
    logic [15:0]   r_rd_delta, r_rd_rem, r_rd_ctx;
    logic [7:0]    r_rd_own;
    logic [2:0]    r_rd_tag;

    bdlt_pkg::t_state r_state, n_state, r_ret, n_ret, r_fret, n_fret;
    logic [NW-1:0] r_n, n_n, r_a, n_a, r_x, n_x, r_lk, n_lk, r_ci, n_ci, r_rid, n_rid;
    logic          r_after, n_after, r_ov, n_ov;
    logic [15:0]   r_len, n_len, r_d, n_d, r_rootd, n_rootd, r_g, n_g;
    logic [2:0]    r_b, n_b, r_st, n_st, r_rtag, n_rtag;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [2:0]    r_kind, n_kind;
    logic [15:0]   r_length, n_length, r_ctx, n_ctx, r_tid, n_tid, r_rctx, n_rctx;
    logic [7:0]    r_tag, n_tag, r_owner, n_owner, r_rown, n_rown;
    logic [2:0]    r_o_st, n_o_st, r_o_tag, n_o_tag;
    logic [7:0]    r_o_id, n_o_id, r_o_own, n_o_own;
    logic [15:0]   r_o_ctx, n_o_ctx;

    logic [NW-1:0] w_ra, w_nx_wa, w_nx_wd, w_pv_wa, w_pv_wd, w_hm_wa, w_hm_wd, w_dl_wa;
    logic          w_nx_we, w_pv_we, w_hm_we, w_dl_we, w_rm_we, w_st_we;
    logic [15:0]   w_dl_wd, w_rm_wd;
    logic [TW-1:0] w_rm_wa;
    logic [NW-1:0] w_rootb;
    logic [2:0]    w_pick;
    bdlt_pkg::t_state w_bnext;

    assign w_rootb = ROOT_B5 + NW'(r_b);
    assign w_bnext = (r_b == B_LAST) ? bdlt_pkg::ST_DONE : bdlt_pkg::ST_BKT0;
    assign w_pick  = bdlt_pkg::pick_bucket(r_len);

    assign i_req.ready          = (r_state == bdlt_pkg::ST_IDLE);
    assign o_rsp.valid          = r_ov;
    assign o_rsp.status         = r_o_st;
    assign o_rsp.result_id      = r_o_id;
    assign o_rsp.result_owner   = r_o_own;
    assign o_rsp.result_tag     = r_o_tag;
    assign o_rsp.result_context = r_o_ctx;

    always_comb begin
        n_state = r_state; n_ret = r_ret; n_fret = r_fret;
        n_n = r_n; n_a = r_a; n_x = r_x; n_lk = r_lk; n_ci = r_ci; n_rid = r_rid;
        n_after = r_after; n_ov = r_ov; n_len = r_len; n_d = r_d; n_rootd = r_rootd;
        n_g = r_g; n_b = r_b; n_st = r_st; n_rtag = r_rtag; n_cnt = r_cnt;
        n_kind = r_kind; n_length = r_length; n_ctx = r_ctx; n_tid = r_tid;
        n_rctx = r_rctx; n_tag = r_tag; n_owner = r_owner; n_rown = r_rown;
        n_o_st = r_o_st; n_o_tag = r_o_tag; n_o_id = r_o_id; n_o_own = r_o_own;
        n_o_ctx = r_o_ctx;
        if (o_rsp.valid && o_rsp.ready) begin
            n_ov = 1'b0;
        end
        unique case (r_state)
            bdlt_pkg::ST_CLR: begin
                n_ci = r_ci + NW'(1);
                if (r_ci == NODE_LAST) begin
                    n_state = bdlt_pkg::ST_IDLE;
                end
            end
            bdlt_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_kind = i_req.kind; n_length = i_req.length; n_tag = i_req.tag;
                    n_ctx = i_req.context_req; n_owner = i_req.owner;
                    n_tid = i_req.timer_id;
                    n_st = bdlt_pkg::STAT_IGN; n_rid = '0; n_rown = '0;
                    n_rtag = '0; n_rctx = '0;
                    unique case (i_req.kind)
                        bdlt_pkg::KIND_SET:  n_state = bdlt_pkg::ST_SET0;
                        bdlt_pkg::KIND_KILL: n_state = bdlt_pkg::ST_KIL0;
                        bdlt_pkg::KIND_TICK: begin
                            n_state = bdlt_pkg::ST_SHR0;
                            n_st = bdlt_pkg::STAT_OK;
                        end
                        bdlt_pkg::KIND_TAKE: n_state = bdlt_pkg::ST_TAK0;
                        bdlt_pkg::KIND_REL:  n_state = bdlt_pkg::ST_REL0;
                        default:             n_state = bdlt_pkg::ST_DONE;
                    endcase
                end
            end
            bdlt_pkg::ST_DONE: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov = 1'b1; n_o_st = r_st; n_o_id = 8'(r_rid); n_o_own = r_rown;
                    n_o_tag = r_rtag; n_o_ctx = r_rctx;
                    n_state = bdlt_pkg::ST_IDLE;
                end
            end
            bdlt_pkg::ST_SET0: n_state = bdlt_pkg::ST_SET1;
            bdlt_pkg::ST_SET1: begin
                if (r_tag >= bdlt_pkg::TAG_LIMIT) begin
                    n_st = bdlt_pkg::STAT_BADTAG; n_state = bdlt_pkg::ST_DONE;
                end else if (r_rd_next >= TCN) begin
                    n_st = bdlt_pkg::STAT_NOFREE; n_state = bdlt_pkg::ST_DONE;
                end else begin
                    n_n = r_rd_next; n_rid = r_rd_next; n_st = bdlt_pkg::STAT_OK;
                    n_fret = bdlt_pkg::ST_DONE; n_state = bdlt_pkg::ST_FIL0;
                end
            end
            bdlt_pkg::ST_KIL0: begin
                n_n = r_tid[NW-1:0];
                n_state = (r_tid >= TC16) ? bdlt_pkg::ST_DONE : bdlt_pkg::ST_KIL1;
            end
            bdlt_pkg::ST_KIL1: begin
                if (r_rd_own != r_owner || r_rd_home == r_n || r_rd_home == ROOT_FREE) begin
                    n_state = bdlt_pkg::ST_DONE;
                end else if (r_rd_home == ROOT_SHORT || r_rd_home == ROOT_EXP) begin
                    n_ret = bdlt_pkg::ST_KIL4; n_state = bdlt_pkg::ST_UNL0;
                end else begin
                    n_x = r_rd_next; n_d = r_rd_delta; n_state = bdlt_pkg::ST_KIL2;
                end
            end
            bdlt_pkg::ST_KIL2: n_state = bdlt_pkg::ST_KIL3;
            bdlt_pkg::ST_KIL3: begin
                n_ret = bdlt_pkg::ST_KIL4; n_state = bdlt_pkg::ST_UNL0;
            end
            bdlt_pkg::ST_KIL4: begin
                n_a = ROOT_FREE; n_after = 1'b1; n_st = bdlt_pkg::STAT_OK;
                n_ret = bdlt_pkg::ST_DONE; n_state = bdlt_pkg::ST_PUT0;
            end
            bdlt_pkg::ST_TAK0: n_state = bdlt_pkg::ST_TAK1;
            bdlt_pkg::ST_TAK1: begin
                if (r_rd_next >= TCN) begin
                    n_st = bdlt_pkg::STAT_NONE; n_state = bdlt_pkg::ST_DONE;
                end else begin
                    n_n = r_rd_next; n_rid = r_rd_next;
                    n_ret = bdlt_pkg::ST_TAK2; n_state = bdlt_pkg::ST_UNL0;
                end
            end
            bdlt_pkg::ST_TAK2: n_state = bdlt_pkg::ST_TAK3;
            bdlt_pkg::ST_TAK3: begin
                n_rown = r_rd_own; n_rtag = r_rd_tag; n_rctx = r_rd_ctx;
                n_st = bdlt_pkg::STAT_OK; n_state = bdlt_pkg::ST_DONE;
            end
            bdlt_pkg::ST_REL0: begin
                n_n = r_tid[NW-1:0];
                n_state = (r_tid >= TC16) ? bdlt_pkg::ST_DONE : bdlt_pkg::ST_REL1;
            end
            bdlt_pkg::ST_REL1: begin
                if (r_rd_home == r_n) begin
                    n_a = ROOT_FREE; n_after = 1'b1; n_st = bdlt_pkg::STAT_OK;
                    n_ret = bdlt_pkg::ST_DONE; n_state = bdlt_pkg::ST_PUT0;
                end else begin
                    n_state = bdlt_pkg::ST_DONE;
                end
            end
            bdlt_pkg::ST_SHR0: n_state = bdlt_pkg::ST_SHR1;
            bdlt_pkg::ST_SHR1: begin
                n_n = r_rd_next; n_cnt = '0; n_b = '0; n_state = bdlt_pkg::ST_SHR2;
            end
            bdlt_pkg::ST_SHR2: begin
                n_state = (r_n >= TCN) ? bdlt_pkg::ST_BKT0 : bdlt_pkg::ST_SHR3;
            end
            bdlt_pkg::ST_SHR3: begin
                n_x = r_rd_next;
                if (r_rd_rem != 16'd0) begin
                    n_state = bdlt_pkg::ST_SHR4;
                end else begin
                    n_ret = bdlt_pkg::ST_SHR5; n_state = bdlt_pkg::ST_UNL0;
                end
            end
            bdlt_pkg::ST_SHR5: begin
                n_a = ROOT_EXP; n_after = 1'b0;
                n_ret = bdlt_pkg::ST_SHR4; n_state = bdlt_pkg::ST_PUT0;
            end
            bdlt_pkg::ST_SHR4: begin
                if (r_x == ROOT_SHORT || r_cnt == CNT_LAST) begin
                    n_state = bdlt_pkg::ST_BKT0;
                end else begin
                    n_n = r_x; n_cnt = r_cnt + CW'(1); n_state = bdlt_pkg::ST_SHR2;
                end
            end
            bdlt_pkg::ST_BKT0: n_state = bdlt_pkg::ST_BKT1;
            bdlt_pkg::ST_BKT1: begin
                if (r_rd_delta == 16'd0 || r_rd_next >= TCN) begin
                    n_b = r_b + 3'd1; n_state = w_bnext;
                end else begin
                    n_n = r_rd_next; n_state = bdlt_pkg::ST_BKT2;
                end
            end
            bdlt_pkg::ST_BKT2: n_state = bdlt_pkg::ST_BKT3;
            bdlt_pkg::ST_BKT3: begin
                if (r_rd_delta != 16'd1) begin
                    n_b = r_b + 3'd1; n_state = w_bnext;
                end else begin
                    n_cnt = '0; n_state = bdlt_pkg::ST_BKT4;
                end
            end
            bdlt_pkg::ST_BKT4: n_state = bdlt_pkg::ST_BKT5;
            bdlt_pkg::ST_BKT5: begin
                if (r_rd_delta != 16'd0) begin
                    n_b = r_b + 3'd1; n_state = w_bnext;
                end else begin
                    n_x = r_rd_next; n_fret = bdlt_pkg::ST_BKT6;
                    n_state = bdlt_pkg::ST_FIL0;
                end
            end
            bdlt_pkg::ST_BKT6: begin
                if (r_x >= TCN || r_cnt == CNT_LAST) begin
                    n_b = r_b + 3'd1; n_state = w_bnext;
                end else begin
                    n_n = r_x; n_cnt = r_cnt + CW'(1); n_state = bdlt_pkg::ST_BKT4;
                end
            end
            bdlt_pkg::ST_FIL0: n_state = bdlt_pkg::ST_FIL1;
            bdlt_pkg::ST_FIL1: begin
                n_len = r_rd_rem; n_ret = bdlt_pkg::ST_FIL2; n_state = bdlt_pkg::ST_UNL0;
            end
            bdlt_pkg::ST_FIL2: begin
                n_after = 1'b0;
                if (r_len == 16'd0) begin
                    n_a = ROOT_EXP;
                end else if (r_len < bdlt_pkg::SHORT_LIMIT) begin
                    n_a = ROOT_SHORT;
                end else begin
                    n_a = ROOT_B5 + NW'(w_pick);
                    n_g = bdlt_pkg::bucket_gran(w_pick);
                end
                n_ret = bdlt_pkg::ST_FIL3; n_state = bdlt_pkg::ST_PUT0;
            end
            bdlt_pkg::ST_FIL3: begin
                n_state = (r_len < bdlt_pkg::SHORT_LIMIT) ? r_fret : bdlt_pkg::ST_FIL4;
            end
            bdlt_pkg::ST_FIL4: n_state = r_fret;
            bdlt_pkg::ST_UNL0: n_state = bdlt_pkg::ST_UNL1;
            bdlt_pkg::ST_UNL1: n_state = bdlt_pkg::ST_UNL2;
            bdlt_pkg::ST_UNL2: n_state = r_ret;
            bdlt_pkg::ST_PUT0: n_state = bdlt_pkg::ST_PUT1;
            bdlt_pkg::ST_PUT1: begin
                n_lk = r_after ? r_rd_next : r_rd_prev;
                n_rootd = r_rd_delta; n_state = bdlt_pkg::ST_PUT2;
            end
            bdlt_pkg::ST_PUT2: n_state = r_ret;
            default: n_state = bdlt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        w_ra = r_n;
        w_nx_we = 1'b0; w_nx_wa = '0; w_nx_wd = '0;
        w_pv_we = 1'b0; w_pv_wa = '0; w_pv_wd = '0;
        w_hm_we = 1'b0; w_hm_wa = '0; w_hm_wd = '0;
        w_dl_we = 1'b0; w_dl_wa = '0; w_dl_wd = '0;
        w_rm_we = 1'b0; w_rm_wa = '0; w_rm_wd = '0;
        w_st_we = 1'b0;
        unique case (r_state)
            bdlt_pkg::ST_CLR: begin
                w_nx_we = 1'b1; w_pv_we = 1'b1; w_hm_we = 1'b1; w_dl_we = 1'b1;
                w_nx_wa = r_ci; w_pv_wa = r_ci; w_hm_wa = r_ci; w_dl_wa = r_ci;
                if (r_ci < TCN) begin
                    w_nx_wd = (r_ci == TIMER_LAST) ? ROOT_FREE : r_ci + NW'(1);
                    w_pv_wd = (r_ci == '0) ? ROOT_FREE : r_ci - NW'(1);
                    w_hm_wd = ROOT_FREE;
                    w_rm_we = 1'b1; w_rm_wa = r_ci[TW-1:0];
                end else if (r_ci == ROOT_FREE) begin
                    w_nx_wd = '0; w_pv_wd = TIMER_LAST; w_hm_wd = ROOT_FREE;
                end else begin
                    w_nx_wd = r_ci; w_pv_wd = r_ci; w_hm_wd = r_ci;
                end
            end
            bdlt_pkg::ST_SET0: w_ra = ROOT_FREE;
            bdlt_pkg::ST_SET1: begin
                if (r_tag < bdlt_pkg::TAG_LIMIT && r_rd_next < TCN) begin
                    w_st_we = 1'b1; w_rm_we = 1'b1;
                    w_rm_wa = r_rd_next[TW-1:0]; w_rm_wd = r_length;
                end
            end
            bdlt_pkg::ST_KIL0, bdlt_pkg::ST_REL0: w_ra = r_tid[NW-1:0];
            bdlt_pkg::ST_KIL2: w_ra = r_x;
            bdlt_pkg::ST_KIL3: begin
                w_dl_we = 1'b1; w_dl_wa = r_x;
                w_dl_wd = (r_x >= TCN) ? r_rd_delta - r_d : r_rd_delta + r_d;
            end
            bdlt_pkg::ST_TAK0: w_ra = ROOT_EXP;
            bdlt_pkg::ST_SHR0: w_ra = ROOT_SHORT;
            bdlt_pkg::ST_SHR3: begin
                if (r_rd_rem != 16'd0) begin
                    w_rm_we = 1'b1; w_rm_wa = r_n[TW-1:0]; w_rm_wd = r_rd_rem - 16'd1;
                end
            end
            bdlt_pkg::ST_BKT0: w_ra = w_rootb;
            bdlt_pkg::ST_BKT1: begin
                if (r_rd_delta != 16'd0) begin
                    w_dl_we = 1'b1; w_dl_wa = w_rootb; w_dl_wd = r_rd_delta - 16'd1;
                end
            end
            bdlt_pkg::ST_BKT3: begin
                w_dl_we = 1'b1; w_dl_wa = r_n; w_dl_wd = r_rd_delta - 16'd1;
            end
            bdlt_pkg::ST_FIL3: begin
                if (r_len >= bdlt_pkg::SHORT_LIMIT) begin
                    w_rm_we = 1'b1; w_rm_wa = r_n[TW-1:0]; w_rm_wd = r_len - r_g;
                    w_dl_we = 1'b1; w_dl_wa = r_n; w_dl_wd = r_g - r_rootd;
                end
            end
            bdlt_pkg::ST_FIL4: begin
                w_dl_we = 1'b1; w_dl_wa = r_a; w_dl_wd = r_g;
            end
            bdlt_pkg::ST_UNL1: begin
                w_nx_we = 1'b1; w_nx_wa = r_rd_prev; w_nx_wd = r_rd_next;
                w_pv_we = 1'b1; w_pv_wa = r_rd_next; w_pv_wd = r_rd_prev;
            end
            bdlt_pkg::ST_UNL2: begin
                w_nx_we = 1'b1; w_nx_wa = r_n; w_nx_wd = r_n;
                w_pv_we = 1'b1; w_pv_wa = r_n; w_pv_wd = r_n;
                w_hm_we = 1'b1; w_hm_wa = r_n; w_hm_wd = r_n;
            end
            bdlt_pkg::ST_PUT0: w_ra = r_a;
            bdlt_pkg::ST_PUT1: begin
                w_hm_we = 1'b1; w_hm_wa = r_n; w_hm_wd = r_rd_home;
                w_nx_we = 1'b1; w_nx_wa = r_n; w_nx_wd = r_after ? r_rd_next : r_a;
                w_pv_we = 1'b1; w_pv_wa = r_n; w_pv_wd = r_after ? r_a : r_rd_prev;
            end
            bdlt_pkg::ST_PUT2: begin
                w_nx_we = 1'b1; w_nx_wa = r_after ? r_a : r_lk; w_nx_wd = r_n;
                w_pv_we = 1'b1; w_pv_wa = r_after ? r_lk : r_a; w_pv_wd = r_n;
            end
            default: w_ra = r_n;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_nx_we) r_mem_next[w_nx_wa] <= w_nx_wd;
        if (w_pv_we) r_mem_prev[w_pv_wa] <= w_pv_wd;
        if (w_hm_we) r_mem_home[w_hm_wa] <= w_hm_wd;
        if (w_dl_we) r_mem_delta[w_dl_wa] <= w_dl_wd;
        if (w_rm_we) r_mem_rem[w_rm_wa] <= w_rm_wd;
        if (w_st_we) begin
            r_mem_own[w_rm_wa] <= r_owner;
            r_mem_tag[w_rm_wa] <= r_tag[2:0];
            r_mem_ctx[w_rm_wa] <= r_ctx;
        end
        r_rd_next  <= r_mem_next[w_ra];
        r_rd_prev  <= r_mem_prev[w_ra];
        r_rd_home  <= r_mem_home[w_ra];
        r_rd_delta <= r_mem_delta[w_ra];
        r_rd_rem   <= r_mem_rem[w_ra[TW-1:0]];
        r_rd_own   <= r_mem_own[w_ra[TW-1:0]];
        r_rd_tag   <= r_mem_tag[w_ra[TW-1:0]];
        r_rd_ctx   <= r_mem_ctx[w_ra[TW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bdlt_pkg::ST_CLR;
            r_ret   <= bdlt_pkg::ST_IDLE;
            r_fret  <= bdlt_pkg::ST_IDLE;
            r_ci    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_fret  <= n_fret;
            r_ci    <= n_ci;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n <= n_n; r_a <= n_a; r_x <= n_x; r_lk <= n_lk; r_rid <= n_rid;
        r_after <= n_after; r_len <= n_len; r_d <= n_d; r_rootd <= n_rootd;
        r_g <= n_g; r_b <= n_b; r_st <= n_st; r_rtag <= n_rtag; r_cnt <= n_cnt;
        r_kind <= n_kind; r_length <= n_length; r_ctx <= n_ctx; r_tid <= n_tid;
        r_rctx <= n_rctx; r_tag <= n_tag; r_owner <= n_owner; r_rown <= n_rown;
        r_o_st <= n_o_st; r_o_tag <= n_o_tag; r_o_id <= n_o_id; r_o_own <= n_o_own;
        r_o_ctx <= n_o_ctx;
    end

    `BDLT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready, "ready held after accepted transaction")
    `BDLT_ASSERT(a_error_no_id, i_clk, i_rst_n, o_rsp.valid && o_rsp.status != bdlt_pkg::STAT_OK |-> o_rsp.result_id == 8'd0, "failed transaction carries an id")
    `BDLT_ASSERT_NEXT(a_done_loads, i_clk, i_rst_n, r_state == bdlt_pkg::ST_DONE && (!r_ov || o_rsp.ready), r_ov && r_state == bdlt_pkg::ST_IDLE, "result not loaded from DONE")
    `BDLT_ASSERT_NEXT(a_kind_held, i_clk, i_rst_n, r_state != bdlt_pkg::ST_IDLE && r_state != bdlt_pkg::ST_CLR, $stable(r_kind), "captured kind changed while busy")

endmodule

### tb/bucketed_delta_list_timer_engine_test.sv
`timescale 1ns / 100ps

module bucketed_delta_list_timer_engine_test;
    import bdlt_pkg::*;

    localparam int NTMR    = 256;
    localparam int NNODE   = NTMR + 11;
    localparam int R_FREE  = NTMR;
    localparam int R_EXP   = NTMR + 1;
    localparam int R_SHORT = NTMR + 2;
    localparam int R_B0    = NTMR + 3;
    localparam logic [15:0] GRAN [8] = '{16'd5, 16'd10, 16'd50, 16'd100,
                                         16'd500, 16'd1000, 16'd5000, 16'd10000};
    localparam logic [2:0] KIND_RSVD_A = 3'd5;
    localparam logic [2:0] KIND_RSVD_B = 3'd6;
    localparam logic [2:0] KIND_RSVD_C = 3'd7;

    typedef struct {
        logic [2:0]  kind;
        logic [15:0] length;
        logic [7:0]  tag;
        logic [15:0] ctx;
        logic [7:0]  owner;
        logic [15:0] timer_id;
    } timer_req_t;

    typedef struct {
        logic [2:0]  status;
        logic [7:0]  id;
        logic [7:0]  owner;
        logic [2:0]  tag;
        logic [15:0] ctx;
    } timer_rsp_t;

    logic i_clk;
    logic i_rst_n;

    bdlt_req_if req();
    bdlt_rsp_if rsp();

    bucketed_delta_list_timer_engine dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req),
        .o_rsp  (rsp)
    );

    int          nxt [NNODE];
    int          prv [NNODE];
    int          home[NNODE];
    logic [15:0] dlt [NNODE];
    logic [15:0] rem [NTMR];
    logic [7:0]  own_m[NTMR];
    logic [2:0]  tag_m[NTMR];
    logic [15:0] ctx_m[NTMR];
    bit          was_set[NTMR];
    int          popped_ids[$];

    timer_rsp_t  pending_rsp[$];
    bit          idle_on;
    int          hold_left;
    int          mismatches;
    int          n_sent;
    int          n_checked;
    int          n_expired;
    int          n_nofree;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic void detach(int n);
        int p;
        int x;
        p = prv[n];
        x = nxt[n];
        nxt[p] = x;
        prv[x] = p;
        nxt[n] = n;
        prv[n] = n;
        home[n] = n;
    endfunction

    function automatic void insert_before(int a, int n);
        int p;
        p = prv[a];
        home[n] = home[a];
        nxt[n] = a;
        prv[n] = p;
        nxt[p] = n;
        prv[a] = n;
    endfunction

    function automatic void insert_after(int a, int n);
        int x;
        x = nxt[a];
        home[n] = home[a];
        nxt[n] = x;
        prv[n] = a;
        prv[x] = n;
        nxt[a] = n;
    endfunction

    function automatic int bucket_of(logic [15:0] len);
        if (len < 16'd10) return 0;
        if (len < 16'd50) return 1;
        if (len < 16'd100) return 2;
        if (len < 16'd500) return 3;
        if (len < 16'd1000) return 4;
        if (len < 16'd5000) return 5;
        return 6;
    endfunction

    function automatic void refile(int n);
        logic [15:0] len;
        logic [15:0] g;
        int r;
        len = rem[n];
        detach(n);
        if (len < 16'd5) begin
            insert_before((len == 16'd0) ? R_EXP : R_SHORT, n);
        end else begin
            r = R_B0 + bucket_of(len);
            insert_before(r, n);
            g = GRAN[r - R_B0];
            rem[n] = len - g;
            dlt[n] = g - dlt[r];
            dlt[r] = g;
        end
    endfunction

    function automatic void count_short();
        int item;
        int nx;
        item = nxt[R_SHORT];
        for (int k = 0; k < NTMR; k++) begin
            if (item >= NTMR) break;
            nx = nxt[item];
            if (rem[item] != 16'd0) begin
                rem[item] = rem[item] - 16'd1;
            end else begin
                detach(item);
                insert_before(R_EXP, item);
            end
            if (nx == R_SHORT) break;
            item = nx;
        end
    endfunction

    function automatic void count_bucket(int r);
        int item;
        int nx;
        if (dlt[r] == 16'd0) return;
        dlt[r] = dlt[r] - 16'd1;
        item = nxt[r];
        if (item >= NTMR) return;
        dlt[item] = dlt[item] - 16'd1;
        if (dlt[item] != 16'd0) return;
        for (int k = 0; k < NTMR; k++) begin
            nx = nxt[item];
            refile(item);
            if (nx == r) break;
            item = nx;
            if (item >= NTMR) break;
            if (dlt[item] != 16'd0) break;
        end
    endfunction

    function automatic void pool_reset();
        for (int i = NTMR; i < NNODE; i++) begin
            nxt[i] = i;
            prv[i] = i;
            home[i] = i;
            dlt[i] = '0;
        end
        for (int i = 0; i < NTMR; i++) begin
            rem[i] = '0;
            dlt[i] = '0;
            own_m[i] = '0;
            tag_m[i] = '0;
            ctx_m[i] = '0;
            was_set[i] = 1'b0;
            insert_before(R_FREE, i);
        end
    endfunction

    function automatic timer_rsp_t timer_pool_step(timer_req_t q);
        timer_rsp_t o;
        int n;
        int r;
        int x;
        o = '{STAT_IGN, 8'd0, 8'd0, 3'd0, 16'd0};
        case (q.kind)
            KIND_SET: begin
                n = nxt[R_FREE];
                if (q.tag >= 8'd8) begin
                    o.status = STAT_BADTAG;
                end else if (n == R_FREE || n >= NTMR) begin
                    o.status = STAT_NOFREE;
                end else begin
                    ctx_m[n] = q.ctx;
                    tag_m[n] = q.tag[2:0];
                    own_m[n] = q.owner;
                    was_set[n] = 1'b1;
                    rem[n] = q.length;
                    refile(n);
                    o.status = STAT_OK;
                    o.id = n[7:0];
                end
            end
            KIND_KILL: begin
                if (q.timer_id < NTMR && own_m[q.timer_id] == q.owner) begin
                    n = q.timer_id;
                    r = home[n];
                    if (r != n && r != R_FREE) begin
                        if (r != R_SHORT && r != R_EXP) begin
                            x = nxt[n];
                            if (x == r) dlt[r] = dlt[r] - dlt[n];
                            else dlt[x] = dlt[x] + dlt[n];
                        end
                        detach(n);
                        insert_after(R_FREE, n);
                        o.status = STAT_OK;
                    end
                end
            end
            KIND_TICK: begin
                count_short();
                for (int b = 0; b < 8; b++) count_bucket(R_B0 + b);
                o.status = STAT_OK;
            end
            KIND_TAKE: begin
                n = nxt[R_EXP];
                if (n == R_EXP || n >= NTMR) begin
                    o.status = STAT_NONE;
                end else begin
                    detach(n);
                    o.status = STAT_OK;
                    o.id = n[7:0];
                    o.owner = own_m[n];
                    o.tag = tag_m[n];
                    o.ctx = ctx_m[n];
                end
            end
            KIND_REL: begin
                if (q.timer_id < NTMR && home[q.timer_id] == q.timer_id) begin
                    insert_after(R_FREE, q.timer_id);
                    o.status = STAT_OK;
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic send_item(timer_req_t q);
        timer_rsp_t o;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        req.valid       <= 1'b1;
        req.kind        <= q.kind;
        req.length      <= q.length;
        req.tag         <= q.tag;
        req.context_req <= q.ctx;
        req.owner       <= q.owner;
        req.timer_id    <= q.timer_id;
        do @(posedge i_clk); while (!req.ready);
        o = timer_pool_step(q);
        if (q.kind == KIND_TAKE && o.status == STAT_OK) begin
            popped_ids.push_back(o.id);
            n_expired++;
        end
        if (q.kind == KIND_SET && o.status == STAT_NOFREE) n_nofree++;
        pending_rsp.push_back(o);
        n_sent++;
        @(negedge i_clk);
    endtask

    function automatic timer_req_t mk(logic [2:0] k, logic [15:0] len, logic [7:0] tg,
                                      logic [7:0] ow, logic [15:0] id);
        timer_req_t q;
        q.kind = k;
        q.length = len;
        q.tag = tg;
        q.ctx = 16'($urandom);
        q.owner = ow;
        q.timer_id = id;
        return q;
    endfunction

    function automatic logic [15:0] rand_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 16'($urandom_range(0, 12));
        if (p < 85) return 16'($urandom_range(13, 150));
        if (p < 95) return 16'($urandom_range(151, 1500));
        return 16'($urandom);
    endfunction

    function automatic timer_req_t rand_item();
        timer_req_t q;
        int p;
        int id;
        p = $urandom_range(0, 99);
        q = mk(KIND_TICK, 16'($urandom), 8'($urandom_range(0, 7)), 8'($urandom),
               16'($urandom));
        if (p < 30) begin
            q.kind = KIND_SET;
            q.length = rand_len();
            if ($urandom_range(0, 15) == 0) q.tag = 8'($urandom_range(8, 255));
        end else if (p < 60) begin
            q.kind = KIND_TICK;
        end else if (p < 78) begin
            q.kind = KIND_TAKE;
        end else if (p < 89) begin
            q.kind = KIND_KILL;
            id = $urandom_range(0, NTMR - 1);
            if ($urandom_range(0, 7) == 0) begin
                q.timer_id = 16'($urandom_range(NTMR, 65535));
            end else if (was_set[id]) begin
                q.timer_id = id;
                if ($urandom_range(0, 5) != 0) q.owner = own_m[id];
            end else begin
                q.kind = KIND_TICK;
            end
        end else if (p < 98) begin
            q.kind = KIND_REL;
            if (popped_ids.size() > 0 && $urandom_range(0, 3) != 0)
                q.timer_id = popped_ids.pop_front();
            else if ($urandom_range(0, 1) == 0)
                q.timer_id = 16'($urandom_range(0, NTMR - 1));
        end else begin
            case ($urandom_range(0, 2))
                0: q.kind = KIND_RSVD_A;
                1: q.kind = KIND_RSVD_B;
                default: q.kind = KIND_RSVD_C;
            endcase
        end
        return q;
    endfunction

    initial begin
        rsp.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp.valid && rsp.ready) begin
                if (pending_rsp.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction: status %0d id %0d",
                                 rsp.status, rsp.result_id);
                end else begin
                    timer_rsp_t e;
                    e = pending_rsp.pop_front();
                    n_checked++;
                    if (rsp.status !== e.status || rsp.result_id !== e.id ||
                        rsp.result_owner !== e.owner || rsp.result_tag !== e.tag ||
                        rsp.result_context !== e.ctx) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch #%0d: exp st %0d id %0d own %0d tag %0d ctx %h, got st %0d id %0d own %0d tag %0d ctx %h",
                                     n_checked, e.status, e.id, e.owner, e.tag, e.ctx,
                                     rsp.status, rsp.result_id, rsp.result_owner,
                                     rsp.result_tag, rsp.result_context);
                    end
                end
            end
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                rsp.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 16) - 1) @(negedge i_clk);
            end else begin
                rsp.ready <= 1'b1;
            end
        end
    end

    task automatic test_filing_ranges();
        logic [15:0] lens[17] = '{16'd0, 16'd1, 16'd4, 16'd5, 16'd9, 16'd10, 16'd49,
                                  16'd50, 16'd99, 16'd100, 16'd499, 16'd500, 16'd999,
                                  16'd1000, 16'd4999, 16'd5000, 16'd65535};
        foreach (lens[i]) send_item(mk(KIND_SET, lens[i], 8'(i % 8), 8'(i * 15), 16'd0));
        repeat (3) send_item(mk(KIND_TICK, 16'd0, 8'd0, 8'd0, 16'd0));
    endtask

    task automatic test_odd_requests();
        send_item(mk(KIND_SET, 16'd3, 8'd8, 8'd1, 16'd0));
        send_item(mk(KIND_SET, 16'd3, 8'd255, 8'd255, 16'hffff));
        send_item(mk(KIND_KILL, 16'd0, 8'd0, 8'(own_m[3] + 8'd1), 16'd3));
        send_item(mk(KIND_KILL, 16'd0, 8'd0, 8'd0, 16'hffff));
        send_item(mk(KIND_KILL, 16'd0, 8'd0, own_m[12], 16'd12));
        send_item(mk(KIND_REL, 16'd0, 8'd0, 8'd0, 16'd11));
        send_item(mk(KIND_REL, 16'd0, 8'd0, 8'd0, 16'd256));
        repeat (3) send_item(mk(KIND_TAKE, 16'd0, 8'd0, 8'd0, 16'd0));
        while (popped_ids.size() > 0)
            send_item(mk(KIND_REL, 16'd0, 8'd0, 8'd0, 16'(popped_ids.pop_front())));
        send_item(mk(KIND_RSVD_A, 16'd0, 8'd0, 8'd0, 16'd0));
        send_item(mk(KIND_RSVD_C, 16'd0, 8'd0, 8'd0, 16'd0));
        repeat (8) send_item(mk(KIND_TAKE, 16'd0, 8'd0, 8'd0, 16'd0));
    endtask

    task automatic test_pool_exhaust();
        while (nxt[R_FREE] != R_FREE)
            send_item(mk(KIND_SET, 16'hffff, 8'($urandom_range(0, 7)), 8'($urandom),
                         16'd0));
        repeat (2) send_item(mk(KIND_SET, 16'd7, 8'd0, 8'd0, 16'd0));
        for (int i = 0; i < NTMR; i++) begin
            if (home[i] == i) send_item(mk(KIND_REL, 16'd0, 8'd0, 8'd0, 16'(i)));
            else if (home[i] != R_FREE) send_item(mk(KIND_KILL, 16'd0, 8'd0, own_m[i], 16'(i)));
        end
        popped_ids.delete();
    endtask

    task automatic test_output_stall();
        hold_left = 300;
        repeat (12) send_item(rand_item());
    endtask

    task automatic test_random_mix(int count);
        repeat (count) send_item(rand_item());
    endtask

    initial begin
        i_rst_n = 1'b0;
        req.valid = 1'b0;
        req.kind = KIND_SET;
        req.length = '0;
        req.tag = '0;
        req.context_req = '0;
        req.owner = '0;
        req.timer_id = '0;
        idle_on = 1'b1;
        hold_left = 0;
        mismatches = 0;
        n_sent = 0;
        n_checked = 0;
        n_expired = 0;
        n_nofree = 0;
        pool_reset();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_filing_ranges();
        test_odd_requests();
        test_pool_exhaust();
        test_output_stall();
        test_random_mix(500);
        idle_on = 1'b0;
        test_random_mix(100);

        req.valid <= 1'b0;
        while (pending_rsp.size() > 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        $display("sent %0d transactions, checked %0d, %0d expired timers taken, %0d sets refused",
                 n_sent, n_checked, n_expired, n_nofree);
        $display("covered all bucket ranges, bad tags, kills, releases and pool exhaustion");
        if (mismatches == 0 && pending_rsp.size() == 0) begin
            $display("bucketed_delta_list_timer_engine regression: pass");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("bucketed_delta_list_timer_engine regression: fail");
        end
        $finish;
    end

    initial begin
        #60000000;
        $display("timeout with %0d results outstanding", pending_rsp.size());
        $display("bucketed_delta_list_timer_engine regression: fail");
        $finish;
    end

endmodule
